@@ sv/sotrs_pkg.sv @@
// ----------------------------------------------------------------------------
// sotrs_pkg
// Shared types, constants and helpers for the second-order transport ray sweep.
// ----------------------------------------------------------------------------
`default_nettype none

package sotrs_pkg;

   localparam int NUM_COORDS      = 6;
   localparam int COEF_COUNT      = NUM_COORDS * NUM_COORDS * (1 + NUM_COORDS);
   localparam int COEF_W          = 32;
   localparam int RAYS_DEFAULT    = 3;
   localparam int TERMS_PER_ROW   = 12;
   localparam int SWEEP_W         = 33;
   localparam int RECIP_SHIFT     = 33;

   localparam logic signed [31:0] X_START      = 32'sd655;
   localparam logic signed [31:0] HALF_PI_Q28  = 32'sd421657428;
   localparam logic signed [31:0] FAN_Q28      = 32'sd5676104;
   localparam logic [9:0]         ROUND_HALF   = 10'd500;
   // 2^28 = 268435 * 1000 + 456
   localparam logic signed [31:0] Q28_PER_HI   = 32'sd268435;
   localparam logic [28:0]        HI_REM       = 29'd456;
   // ceil(2^33 / 125), exact for dividends below 2^26
   localparam logic signed [31:0] RECIP_125    = 32'sd68719477;

   typedef enum logic [2:0] {
      REG_SWEEP_MODE        = 3'd0,
      REG_ANGLE_HALF_RANGE  = 3'd1,
      REG_ANGLE_STEP        = 3'd2,
      REG_OFFSET_HALF_RANGE = 3'd3,
      REG_OFFSET_STEP       = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADDR,
      ST_SQ,
      ST_MUL,
      ST_ACC,
      ST_ROW,
      ST_DIV,
      ST_FIN,
      ST_RAY,
      ST_DONE
   } state_type;

   // slot 0 = x, slot 1 = swept angle, slot 2 = swept offset
   typedef struct packed {
      logic       quad;
      logic [1:0] j;
      logic [1:0] k;
   } term_type;

   function automatic term_type term_info(input logic [3:0] t);
      term_type r;
      r.quad = 1'b1;
      r.j    = 2'd0;
      r.k    = 2'd0;
      case (t)
         4'd0:    begin r.quad = 1'b0; r.j = 2'd0; end
         4'd1:    begin r.quad = 1'b0; r.j = 2'd1; end
         4'd2:    begin r.quad = 1'b0; r.j = 2'd2; end
         4'd3:    begin r.j = 2'd0; r.k = 2'd0; end
         4'd4:    begin r.j = 2'd0; r.k = 2'd1; end
         4'd5:    begin r.j = 2'd0; r.k = 2'd2; end
         4'd6:    begin r.j = 2'd1; r.k = 2'd0; end
         4'd7:    begin r.j = 2'd1; r.k = 2'd1; end
         4'd8:    begin r.j = 2'd1; r.k = 2'd2; end
         4'd9:    begin r.j = 2'd2; r.k = 2'd0; end
         4'd10:   begin r.j = 2'd2; r.k = 2'd1; end
         4'd11:   begin r.j = 2'd2; r.k = 2'd2; end
         default: begin r.j = 2'd0; r.k = 2'd0; end
      endcase
      return r;
   endfunction

   function automatic logic [2:0] slot_coord(input logic mode, input logic [1:0] slot);
      logic [2:0] c;
      case (slot)
         2'd1:    c = mode ? 3'd1 : 3'd3;
         2'd2:    c = mode ? 3'd5 : 3'd2;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] row_coord(input logic mode, input logic row);
      logic [2:0] c;
      if (mode) begin
         c = row ? 3'd1 : 3'd0;
      end else begin
         c = row ? 3'd3 : 3'd2;
      end
      return c;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/second_order_transport_ray_sweep.sv @@
// ----------------------------------------------------------------------------
// second_order_transport_ray_sweep
// Sweeps an angle/offset grid and maps each point through R*in + T*in*in.
// ----------------------------------------------------------------------------
// Load word: no result. Ray word at a new grid point: for each of two rows, 12 terms
// each pass address, square, multiply and accumulate states on the one shared 32x32
// multiplier, then a row state; then the divide by 1000 by reciprocal multiply, finish, output.
// Other rays and the done word go straight to the output state. busy is high from
// acceptance until the result strobe cycle, in which the next word can be taken.
// Synchronous reset clears control, sweep state and coefficient valid bits, and sets config to defaults.
`default_nettype none

module second_order_transport_ray_sweep #(
   parameter int RAYS_PER_POINT = sotrs_pkg::RAYS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_opcode,
   input  wire logic [7:0]         req_coef_index,
   input  wire logic signed [31:0] req_coef_value,
   input  wire logic signed [31:0] req_left_edge,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_ray_x,
   output logic signed [31:0]      rsp_ray_y,
   output logic signed [31:0]      rsp_ray_angle,
   output logic                    rsp_sweep_done,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int FW  = (RAYS_PER_POINT > 1) ? $clog2(RAYS_PER_POINT) : 1;
   localparam int AW  = $clog2(sotrs_pkg::COEF_COUNT);
   localparam int SW  = sotrs_pkg::SWEEP_W;
   localparam int CW  = sotrs_pkg::COEF_W;
   localparam int NC  = sotrs_pkg::NUM_COORDS;

   sotrs_pkg::state_type state_ff, state_in;
   logic [3:0]           term_ff, term_in;
   logic                 row_ff, row_in;
   logic                 div_cnt_ff, div_cnt_in;

   logic                 mode_ff;
   logic [30:0]          ahr_ff, astep_ff, ohr_ff, ostep_ff;

   logic                 started_ff;
   logic signed [SW-1:0] angle_ff, offset_ff;
   logic [FW-1:0]        fan_ff;
   logic signed [31:0]   held_x_ff, held_y_ff, held_angle_ff;

   logic signed [63:0]   prod_ff, acc_ff, quo_ff;
   logic signed [31:0]   sq_ff, coef_ff;
   logic [31:0]          mag_ff;
   logic [28:0]          rem_ff;
   logic                 neg_ff;

   logic [sotrs_pkg::COEF_COUNT-1:0] valid_ff;
   logic                 vld_rd_ff;
   logic [CW-1:0]        rd_data;

   logic                 accept, csr_wr;
   logic signed [SW-1:0] eff_angle;
   sotrs_pkg::term_type  term;
   logic [2:0]           cj, ck, rc;
   logic [AW-1:0]        rd_addr;
   logic signed [31:0]   val_j, val_k, mul_a, mul_b;
   logic signed [31:0]   row_res, q_sat, ray_angle;
   logic signed [63:0]   quo_sum;
   logic signed [3:0]    fan_s;
   logic signed [31:0]   fan_term;
   logic signed [SW:0]   off_next, ang_next;
   logic                 last_fan;

   function automatic logic signed [31:0] slot_val(input logic [1:0] s,
                                                   input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] o);
      logic signed [31:0] v;
      case (s)
         2'd1:    v = a[31:0];
         2'd2:    v = o[31:0];
         default: v = sotrs_pkg::X_START;
      endcase
      return v;
   endfunction

   assign accept = start && !busy;
   assign csr_wr = psel && penable && pwrite && pready;
   assign busy   = (state_ff != sotrs_pkg::ST_IDLE);
   assign pready = 1'b1;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b1;
         ahr_ff   <= '0;
         astep_ff <= 31'd65536;
         ohr_ff   <= '0;
         ostep_ff <= 31'd65536;
      end else if (csr_wr) begin
         case (paddr[4:2])
            sotrs_pkg::REG_SWEEP_MODE:        mode_ff  <= pwdata[0];
            sotrs_pkg::REG_ANGLE_HALF_RANGE:  ahr_ff   <= pwdata[30:0];
            sotrs_pkg::REG_ANGLE_STEP:        astep_ff <= pwdata[30:0];
            sotrs_pkg::REG_OFFSET_HALF_RANGE: ohr_ff   <= pwdata[30:0];
            sotrs_pkg::REG_OFFSET_STEP:       ostep_ff <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         sotrs_pkg::REG_SWEEP_MODE:        prdata = {31'd0, mode_ff};
         sotrs_pkg::REG_ANGLE_HALF_RANGE:  prdata = {1'b0, ahr_ff};
         sotrs_pkg::REG_ANGLE_STEP:        prdata = {1'b0, astep_ff};
         sotrs_pkg::REG_OFFSET_HALF_RANGE: prdata = {1'b0, ohr_ff};
         sotrs_pkg::REG_OFFSET_STEP:       prdata = {1'b0, ostep_ff};
         default:                          prdata = '0;
      endcase
   end

   // coefficient store
   sotrs_ram #(
      .WIDTH(CW),
      .DEPTH(sotrs_pkg::COEF_COUNT)
   ) u_coef_ram (
      .clock  (clock),
      .wr_en  (accept && !req_opcode && (req_coef_index < 8'(sotrs_pkg::COEF_COUNT))),
      .wr_addr(req_coef_index[AW-1:0]),
      .wr_data(req_coef_value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (accept && !req_opcode && (req_coef_index < 8'(sotrs_pkg::COEF_COUNT))) begin
         valid_ff[req_coef_index[AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      vld_rd_ff <= valid_ff[rd_addr];
   end

   // term decode
   assign term    = sotrs_pkg::term_info(term_ff);
   assign cj      = sotrs_pkg::slot_coord(mode_ff, term.j);
   assign ck      = sotrs_pkg::slot_coord(mode_ff, term.k);
   assign rc      = sotrs_pkg::row_coord(mode_ff, row_ff);
   assign rd_addr = term.quad
                    ? AW'(NC * NC) + AW'(rc) * AW'(NC * NC) + AW'(cj) * AW'(NC) + AW'(ck)
                    : AW'(rc) * AW'(NC) + AW'(cj);
   assign val_j   = slot_val(term.j, angle_ff, offset_ff);
   assign val_k   = slot_val(term.k, angle_ff, offset_ff);

   // shared multiplier operands
   always_comb begin
      if (state_ff == sotrs_pkg::ST_MUL) begin
         mul_a = coef_ff;
         mul_b = term.quad ? sq_ff : val_j;
      end else if (state_ff == sotrs_pkg::ST_DIV) begin
         if (div_cnt_ff) begin
            mul_a = $signed({6'd0, rem_ff[28:3]});
            mul_b = sotrs_pkg::RECIP_125;
         end else begin
            mul_a = $signed({16'd0, mag_ff[31:16]});
            mul_b = sotrs_pkg::Q28_PER_HI;
         end
      end else begin
         mul_a = val_j;
         mul_b = val_k;
      end
   end

   assign eff_angle = started_ff ? angle_ff : -$signed(SW'(ahr_ff));
   assign row_res   = sotrs_pkg::sat32((acc_ff + 64'sd2048) >>> 12);
   assign quo_sum   = quo_ff + (prod_ff >>> sotrs_pkg::RECIP_SHIFT);
   assign q_sat     = sotrs_pkg::sat32((neg_ff ? -quo_sum : quo_sum)
                                       + 64'(sotrs_pkg::HALF_PI_Q28));
   assign off_next  = (SW+1)'(offset_ff) + $signed((SW+1)'(ostep_ff));
   assign ang_next  = (SW+1)'(angle_ff) + $signed((SW+1)'(astep_ff));
   assign last_fan  = (fan_ff == FW'(RAYS_PER_POINT - 1));
   assign fan_s     = 4'(fan_ff) - 4'((RAYS_PER_POINT - 1) / 2);
   assign fan_term  = 32'(fan_s) * sotrs_pkg::FAN_Q28;
   assign ray_angle = sotrs_pkg::sat32(64'(held_angle_ff) + 64'(fan_term));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sotrs_pkg::ST_IDLE: begin
            if (accept && req_opcode) begin
               if (fan_ff != '0) begin
                  state_in = sotrs_pkg::ST_RAY;
               end else if (eff_angle > $signed(SW'(ahr_ff))) begin
                  state_in = sotrs_pkg::ST_DONE;
               end else begin
                  state_in = sotrs_pkg::ST_ADDR;
               end
            end
         end
         sotrs_pkg::ST_ADDR: state_in = sotrs_pkg::ST_SQ;
         sotrs_pkg::ST_SQ:   state_in = sotrs_pkg::ST_MUL;
         sotrs_pkg::ST_MUL:  state_in = sotrs_pkg::ST_ACC;
         sotrs_pkg::ST_ACC: begin
            state_in = (term_ff == 4'(sotrs_pkg::TERMS_PER_ROW - 1))
                       ? sotrs_pkg::ST_ROW : sotrs_pkg::ST_ADDR;
         end
         sotrs_pkg::ST_ROW: state_in = row_ff ? sotrs_pkg::ST_DIV : sotrs_pkg::ST_ADDR;
         sotrs_pkg::ST_DIV: begin
            if (div_cnt_ff) begin
               state_in = sotrs_pkg::ST_FIN;
            end
         end
         sotrs_pkg::ST_FIN:  state_in = sotrs_pkg::ST_RAY;
         sotrs_pkg::ST_RAY:  state_in = sotrs_pkg::ST_IDLE;
         sotrs_pkg::ST_DONE: state_in = sotrs_pkg::ST_IDLE;
         default:            state_in = sotrs_pkg::ST_IDLE;
      endcase
   end

   // counters
   always_comb begin
      term_in    = term_ff;
      row_in     = row_ff;
      div_cnt_in = div_cnt_ff;
      unique case (state_ff)
         sotrs_pkg::ST_IDLE: begin
            term_in    = '0;
            row_in     = 1'b0;
            div_cnt_in = 1'b0;
         end
         sotrs_pkg::ST_ACC: term_in = term_ff + 4'd1;
         sotrs_pkg::ST_ROW: begin
            term_in = '0;
            row_in  = 1'b1;
         end
         sotrs_pkg::ST_DIV: div_cnt_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sotrs_pkg::ST_IDLE;
         term_ff    <= '0;
         row_ff     <= 1'b0;
         div_cnt_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         term_ff    <= term_in;
         row_ff     <= row_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // sweep state
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         angle_ff      <= '0;
         offset_ff     <= '0;
         fan_ff        <= '0;
         held_x_ff     <= '0;
         held_y_ff     <= '0;
         held_angle_ff <= '0;
      end else begin
         if (accept && req_opcode && !started_ff) begin
            started_ff <= 1'b1;
            angle_ff   <= -$signed(SW'(ahr_ff));
            offset_ff  <= -$signed(SW'(ohr_ff));
         end
         if (state_ff == sotrs_pkg::ST_IDLE && state_in == sotrs_pkg::ST_ADDR) begin
            held_x_ff <= req_left_edge;
         end
         if (state_ff == sotrs_pkg::ST_ROW && !row_ff) begin
            held_y_ff <= row_res;
         end
         if (state_ff == sotrs_pkg::ST_FIN) begin
            held_angle_ff <= q_sat;
            if (off_next > $signed((SW+1)'(ohr_ff))) begin
               offset_ff <= -$signed(SW'(ohr_ff));
               angle_ff  <= ang_next[SW-1:0];
            end else begin
               offset_ff <= off_next[SW-1:0];
            end
         end
         if (state_ff == sotrs_pkg::ST_RAY) begin
            fan_ff <= last_fan ? '0 : fan_ff + FW'(1);
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == sotrs_pkg::ST_ADDR || state_ff == sotrs_pkg::ST_MUL
          || state_ff == sotrs_pkg::ST_DIV) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
      end
      if (state_ff == sotrs_pkg::ST_SQ) begin
         sq_ff   <= sotrs_pkg::sat32((prod_ff + 64'sd32768) >>> 16);
         coef_ff <= vld_rd_ff ? $signed(rd_data) : 32'sd0;
      end
      if (state_ff == sotrs_pkg::ST_IDLE || state_ff == sotrs_pkg::ST_ROW) begin
         acc_ff <= '0;
      end else if (state_ff == sotrs_pkg::ST_ACC) begin
         acc_ff <= acc_ff + (prod_ff >>> 8);
      end
      // |v| * 4096 / 1000 as hi * 268435 + (hi * 456 + lo * 4096 + 500) / 1000
      if (state_ff == sotrs_pkg::ST_ROW) begin
         neg_ff <= row_res[31];
         mag_ff <= row_res[31] ? 32'(-row_res) : 32'(row_res);
      end
      if (state_ff == sotrs_pkg::ST_DIV) begin
         if (div_cnt_ff) begin
            quo_ff <= prod_ff;
         end else begin
            rem_ff <= 29'(mag_ff[31:16]) * sotrs_pkg::HI_REM
                      + {1'b0, mag_ff[15:0], 12'd0}
                      + 29'(sotrs_pkg::ROUND_HALF);
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= (state_ff == sotrs_pkg::ST_RAY) || (state_ff == sotrs_pkg::ST_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sotrs_pkg::ST_RAY) begin
         rsp_ray_x      <= held_x_ff;
         rsp_ray_y      <= held_y_ff;
         rsp_ray_angle  <= ray_angle;
         rsp_sweep_done <= 1'b0;
      end else if (state_ff == sotrs_pkg::ST_DONE) begin
         rsp_ray_x      <= '0;
         rsp_ray_y      <= '0;
         rsp_ray_angle  <= '0;
         rsp_sweep_done <= 1'b1;
      end
   end

endmodule

`default_nettype wire

@@ sv/sotrs_ram.sv @@
// ----------------------------------------------------------------------------
// sotrs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sotrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 252
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ sv/sotrs_checker.sv @@
// ----------------------------------------------------------------------------
// sotrs_checker
// Port-level checks for the ray sweep, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sotrs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        req_opcode,
   input wire logic        rsp_strobe,
   input wire logic [31:0] rsp_ray_x,
   input wire logic [31:0] rsp_ray_y,
   input wire logic [31:0] rsp_ray_angle,
   input wire logic        rsp_sweep_done
);

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobes in consecutive cycles");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_sweep_done) |->
         (rsp_ray_x == 32'd0 && rsp_ray_y == 32'd0 && rsp_ray_angle == 32'd0))
      else $error("done word carries ray data");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_opcode) |=> (!rsp_strobe && !busy))
      else $error("load word gave a result or held busy");

   a_ray_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode) |=> (busy && !rsp_strobe))
      else $error("ray request did not raise busy");

endmodule

bind second_order_transport_ray_sweep sotrs_checker u_sotrs_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_opcode    (req_opcode),
   .rsp_strobe    (rsp_strobe),
   .rsp_ray_x     (rsp_ray_x),
   .rsp_ray_y     (rsp_ray_y),
   .rsp_ray_angle (rsp_ray_angle),
   .rsp_sweep_done(rsp_sweep_done)
);

`default_nettype wire

@@ dv/second_order_transport_ray_sweep_tb.sv @@
// ----------------------------------------------------------------------------
// second_order_transport_ray_sweep_tb
// Drives coefficient loads and ray requests into the ray sweep, keeps its own
// fixed-point model of the grid sweep and transport map, and checks every
// result word field by field. Registers change over the APB port between
// phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module second_order_transport_ray_sweep_tb;

   localparam int RAYS = 3;
   localparam int NCOEF = 252;
   localparam int CX = 0, CTH = 1, CY = 2, CPHI = 3, CDEL = 5;
   localparam longint XSTART = 655;
   localparam longint PI2_Q28 = 421657428;
   localparam longint FAN_STEP = 5676104;
   localparam logic [31:0] MAX31 = 32'h7FFF_FFFF;
   localparam bit OP_LOAD = 1'b0;
   localparam bit OP_RAY = 1'b1;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] angle;
      logic done;
   } ray_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_opcode = 1'b0;
   logic [7:0] req_coef_index = '0;
   logic signed [31:0] req_coef_value = '0;
   logic signed [31:0] req_left_edge = '0;
   logic rsp_strobe;
   logic signed [31:0] rsp_ray_x, rsp_ray_y, rsp_ray_angle;
   logic rsp_sweep_done;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   second_order_transport_ray_sweep u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_coef_index(req_coef_index),
      .req_coef_value(req_coef_value), .req_left_edge(req_left_edge),
      .rsp_strobe(rsp_strobe), .rsp_ray_x(rsp_ray_x), .rsp_ray_y(rsp_ray_y),
      .rsp_ray_angle(rsp_ray_angle), .rsp_sweep_done(rsp_sweep_done),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model state
   longint coefs[NCOEF];
   bit started;
   longint sw_angle, sw_offset, hx, hy, hang;
   int fan_pos;
   bit m_mode = 1'b1;
   longint m_ahr = 0, m_astep = 65536, m_ohr = 0, m_ostep = 65536;

   ray_word_type ray_q[$];
   int errors = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint map_row(longint vec[6], int row);
      longint acc, sq;
      acc = 0;
      for (int j = 0; j < 6; j++) begin
         acc += (coefs[row*6 + j] * vec[j]) >>> 8;
         for (int k = 0; k < 6; k++) begin
            sq = clamp32((vec[j] * vec[k] + 32768) >>> 16);
            acc += (coefs[36 + row*36 + j*6 + k] * sq) >>> 8;
         end
      end
      return clamp32((acc + 2048) >>> 12);
   endfunction

   function automatic longint mrad_to_q28(longint v);
      longint n;
      n = v * 4096;
      if (n >= 0) return (n + 500) / 1000;
      return -((-n + 500) / 1000);
   endfunction

   function automatic void predict_ray(bit op, logic [7:0] idx,
                                       logic signed [31:0] val,
                                       logic signed [31:0] left);
      longint vec[6];
      longint y, a;
      ray_word_type w;
      if (op == OP_LOAD) begin
         if (idx < NCOEF) coefs[idx] = longint'(val);
         return;
      end
      if (!started) begin
         sw_angle = -m_ahr;
         sw_offset = -m_ohr;
         fan_pos = 0;
         started = 1'b1;
      end
      if (fan_pos == 0) begin
         if (sw_angle > m_ahr) begin
            w.x = '0; w.y = '0; w.angle = '0; w.done = 1'b1;
            ray_q.push_back(w);
            return;
         end
         foreach (vec[i]) vec[i] = 0;
         vec[CX] = XSTART;
         if (m_mode) begin
            vec[CTH] = sw_angle;
            vec[CDEL] = sw_offset;
            y = map_row(vec, CX);
            a = map_row(vec, CTH);
         end else begin
            vec[CPHI] = sw_angle;
            vec[CY] = sw_offset;
            y = map_row(vec, CY);
            a = map_row(vec, CPHI);
         end
         hx = longint'(left);
         hy = y;
         hang = clamp32(PI2_Q28 + mrad_to_q28(a));
         sw_offset += m_ostep;
         if (sw_offset > m_ohr) begin
            sw_offset = -m_ohr;
            sw_angle += m_astep;
         end
      end
      w.x = hx[31:0];
      w.y = hy[31:0];
      w.angle = 32'(clamp32(hang + longint'(fan_pos - (RAYS - 1) / 2) * FAN_STEP));
      w.done = 1'b0;
      ray_q.push_back(w);
      fan_pos = (fan_pos + 1 >= RAYS) ? 0 : fan_pos + 1;
   endfunction

   task automatic send_word(bit op, logic [7:0] idx, logic signed [31:0] val,
                            logic signed [31:0] left);
      @(negedge clock);
      start <= 1'b1;
      req_opcode <= op;
      req_coef_index <= idx;
      req_coef_value <= val;
      req_left_edge <= left;
      do @(posedge clock); while (busy);
      predict_ray(op, idx, val, left);
   endtask

   task automatic sender_gap(int pct);
      if ($urandom_range(99) < pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (ray_q.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(sotrs_pkg::reg_index_type r, logic [31:0] v);
      drain();
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {r, 2'b00}; pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (r)
         sotrs_pkg::REG_SWEEP_MODE:        m_mode = v[0];
         sotrs_pkg::REG_ANGLE_HALF_RANGE:  m_ahr = longint'(v & MAX31);
         sotrs_pkg::REG_ANGLE_STEP:        m_astep = longint'(v & MAX31);
         sotrs_pkg::REG_OFFSET_HALF_RANGE: m_ohr = longint'(v & MAX31);
         sotrs_pkg::REG_OFFSET_STEP:       m_ostep = longint'(v & MAX31);
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   function automatic void check_field(string name, logic [31:0] exp_v,
                                       logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      ray_word_type w;
      if (!reset && rsp_strobe) begin
         if (ray_q.size() == 0) begin
            $display("%0t: unexpected word, actual x %h y %h angle %h done %b",
                     $time, rsp_ray_x, rsp_ray_y, rsp_ray_angle, rsp_sweep_done);
            errors++;
         end else begin
            w = ray_q.pop_front();
            check_field("ray_x", w.x, rsp_ray_x);
            check_field("ray_y", w.y, rsp_ray_y);
            check_field("ray_angle", w.angle, rsp_ray_angle);
            check_field("sweep_done", {31'd0, w.done}, {31'd0, rsp_sweep_done});
         end
      end
   end

   task automatic test_coef_loads();
      send_word(OP_LOAD, 8'd0, 32'sh7FFF_FFFF, '0);
      send_word(OP_LOAD, 8'd0, 32'sd1 <<< 20, '0);
      send_word(OP_LOAD, 8'd35, 32'sh8000_0000, '0);
      send_word(OP_LOAD, 8'd7, 32'sd1 <<< 20, '0);
      send_word(OP_LOAD, 8'd36, $urandom, '0);
      send_word(OP_LOAD, 8'd72 + 8'd7, 32'sd3 <<< 18, '0);
      send_word(OP_LOAD, 8'd251, $urandom, '0);
      send_word(OP_LOAD, 8'd252, 32'sh7FFF_FFFF, '0);
      send_word(OP_LOAD, 8'd255, 32'sh8000_0000, '0);
   endtask

   // ranges still zero: one grid point, then the grid is exhausted
   task automatic test_first_point_and_done();
      send_word(OP_RAY, '0, '0, 32'sh7FFF_FFFF);
      send_word(OP_RAY, '0, '0, 32'sh8000_0000);
      send_word(OP_RAY, '0, '0, '0);
      send_word(OP_RAY, '0, '0, $urandom);
      send_word(OP_RAY, '0, '0, $urandom);
   endtask

   task automatic test_resume_sweep();
      write_reg(sotrs_pkg::REG_SWEEP_MODE, 32'd0);
      write_reg(sotrs_pkg::REG_ANGLE_HALF_RANGE, 32'd20 << 16);
      write_reg(sotrs_pkg::REG_OFFSET_HALF_RANGE, 32'd10 << 16);
      write_reg(sotrs_pkg::REG_ANGLE_STEP, 32'd5 << 16);
      write_reg(sotrs_pkg::REG_OFFSET_STEP, 32'd4 << 16);
      for (int i = 0; i < 7; i++) begin
         if (i == 3) send_word(OP_LOAD, 8'd253, $urandom, '0);
         send_word(OP_RAY, '0, '0, $urandom);
      end
   endtask

   task automatic test_random_sweeps();
      int pct;
      logic [7:0] idx;
      logic signed [31:0] val;
      for (int p = 0; p < 12; p++) begin
         pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 67 : 7);
         write_reg(sotrs_pkg::REG_SWEEP_MODE, p & 1);
         write_reg(sotrs_pkg::REG_ANGLE_HALF_RANGE, (p == 11) ? MAX31 :
                   ((p % 4 == 3) ? 32'd0 : $urandom_range(0, 100 << 16)));
         write_reg(sotrs_pkg::REG_ANGLE_STEP,
                   (p == 10) ? MAX31 : $urandom_range(1, 8 << 16));
         write_reg(sotrs_pkg::REG_OFFSET_HALF_RANGE,
                   (p == 9) ? MAX31 : $urandom_range(0, 100 << 16));
         write_reg(sotrs_pkg::REG_OFFSET_STEP, (p == 8) ? 32'd1 :
                   ((p == 10) ? MAX31 : $urandom_range(1, 40 << 16)));
         for (int i = 0; i < 127; i++) begin
            if ($urandom_range(99) < 25) begin
               idx = 8'($urandom_range(0, 255));
               if ($urandom_range(3) == 0) val = $urandom;
               else val = $signed($urandom_range(0, 1 << 21)) - (32'sd1 <<< 20);
               send_word(OP_LOAD, idx, val, $urandom);
            end else begin
               send_word(OP_RAY, 8'($urandom), $urandom, $urandom);
            end
            sender_gap(pct);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_coef_loads();
      test_first_point_and_done();
      test_resume_sweep();
      test_random_sweeps();
      @(negedge clock);
      start <= 1'b0;
      while (ray_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

@@ second_order_transport_ray_sweep.f @@
sv/sotrs_pkg.sv
sv/sotrs_ram.sv
sv/second_order_transport_ray_sweep.sv
sv/sotrs_checker.sv
dv/second_order_transport_ray_sweep_tb.sv
